// File: src/packed_inode_varint_decoder_top_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef PACKED_INODE_VARINT_DECODER_TOP_MACROS_SVH
`define PACKED_INODE_VARINT_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PIVD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PIVD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PIVD_ASSERT(label, clk, rst_n, prop, msg)
`define PIVD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: src/pivd_pkg.sv
// Shared types and constants of the packed inode varint decoder.
package pivd_pkg;
    localparam int unsigned MaxFieldsDefault    = 25;
    localparam int unsigned PositionBitsDefault = 12;
    localparam int unsigned HeaderBytes         = 14;
    localparam int unsigned TableSlots          = 29;

    localparam logic [2:0] KindSeed   = 3'd0;
    localparam logic [2:0] KindFlags  = 3'd1;
    localparam logic [2:0] KindMode   = 3'd2;
    localparam logic [2:0] KindVarint = 3'd3;
    localparam logic [2:0] KindStatus = 3'd4;

    localparam logic [2:0] ErrOk      = 3'd0;
    localparam logic [2:0] ErrShort   = 3'd1;
    localparam logic [2:0] ErrOldFmt  = 3'd2;
    localparam logic [2:0] ErrFewByte = 3'd3;
    localparam logic [2:0] ErrOverrun = 3'd4;

    localparam logic [1:0] RegSizeOnly = 2'd0;
    localparam logic [1:0] RegNewFmt   = 2'd1;
    localparam logic [1:0] RegWidthTab = 2'd2;

    localparam logic [57:0] WidthTableReset = 58'd206297221024739327;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [63:0] value;
        logic [1:0]  width_code;
        logic [2:0]  error_code;
        logic [4:0]  field_count;
        logic        last_result;
    } t_result;

    // One byte job handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       is_first;   // first byte of a varint
        logic [3:0] len;        // varint length
        logic [3:0] k;          // byte index within the varint
        logic       finish;     // varint completes on this byte
        logic [4:0] slot;
        logic       size_only;
        logic       emit_hdr;   // header result on this byte
        logic [2:0] hdr_kind;
        logic [63:0] hdr_value;
        logic       status;     // status result follows
        logic [2:0] err;
        logic [4:0] fcount;
    } t_job;

    function automatic logic [63:0] width_mask(input logic [1:0] code);
        case (code)
            2'd0:    width_mask = 64'h0000_0000_0000_00FF;
            2'd1:    width_mask = 64'h0000_0000_0000_FFFF;
            2'd2:    width_mask = 64'h0000_0000_FFFF_FFFF;
            default: width_mask = '1;
        endcase
    endfunction
endpackage

// File: src/pivd_front.sv
// Front part: header parsing, varint framing and status classification.
module pivd_front import pivd_pkg::*; #(
    parameter int unsigned MAX_FIELDS    = MaxFieldsDefault,
    parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_size_only,
    input  logic [4:0]  i_new_format_bit,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);
    localparam logic [POSITION_BITS-1:0] PosMax = '1;
    localparam logic [6:0] CapFields = 7'(MAX_FIELDS);

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [63:0] r_hdr, n_hdr;
    logic [31:0] r_flags, n_flags;
    logic [5:0]  r_left, n_left;
    logic [4:0]  r_slot, n_slot;
    logic [3:0]  r_len, n_len;
    logic [3:0]  r_bleft, n_bleft;
    logic [2:0]  r_err, n_err;
    logic [6:0]  nraw, capped;
    logic [3:0]  ones;
    logic [3:0]  len_now, bl_now;
    logic        fire, in_hdr, body;
    t_job        job;

    assign o_ready = i_job_ready;
    assign fire    = i_valid && o_ready;
    assign in_hdr  = r_pos < POSITION_BITS'(HeaderBytes);

    always_comb begin
        ones = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (ones == 4'(i) && i_data_byte[i]) ones = 4'(i + 1);
        end
    end

    always_comb begin
        n_pos = r_pos; n_hdr = r_hdr; n_flags = r_flags; n_left = r_left;
        n_slot = r_slot; n_len = r_len; n_bleft = r_bleft; n_err = r_err;
        nraw = r_flags[30:24];
        capped = (nraw <= CapFields) ? nraw : CapFields;
        job = '0;
        job.data = i_data_byte;
        job.size_only = i_size_only;
        job.slot = r_slot;
        len_now = r_len;
        bl_now = r_bleft;
        body = 1'b0;
        if (in_hdr) begin
            n_hdr = {i_data_byte, r_hdr[63:8]};
            if (r_pos == POSITION_BITS'(7)) begin
                job.emit_hdr = !i_size_only; job.hdr_kind = KindSeed;
                job.hdr_value = n_hdr;
            end else if (r_pos == POSITION_BITS'(11)) begin
                n_flags = n_hdr[63:32];
                job.emit_hdr = !i_size_only; job.hdr_kind = KindFlags;
                job.hdr_value = {32'd0, n_hdr[63:32]};
            end else if (r_pos == POSITION_BITS'(13)) begin
                job.emit_hdr = !i_size_only; job.hdr_kind = KindMode;
                job.hdr_value = {48'd0, n_hdr[63:48]};
                if (!r_flags[i_new_format_bit]) begin
                    n_err = ErrOldFmt; n_left = 6'd0;
                end else if (i_size_only) begin
                    n_left = (nraw >= 7'd5) ? 6'd9 : 6'd0;
                end else begin
                    n_left = (capped < 7'd4) ? 6'({capped, 1'b0}) : 6'(capped + 7'd4);
                end
                n_slot = 5'd0; n_bleft = 4'd0;
            end
        end else if (r_err == ErrOk && r_left != 6'd0) begin
            body = 1'b1;
            if (r_bleft == 4'd0) begin
                len_now = ones + 4'd1;
                bl_now = len_now;
                job.is_first = 1'b1;
            end
            n_len = len_now;
            n_bleft = bl_now - 4'd1;
            job.len = len_now;
            job.k = len_now - bl_now;
            if (n_bleft == 4'd0) begin
                job.finish = 1'b1;
                n_slot = r_slot + 5'd1;
                n_left = r_left - 6'd1;
            end
        end
        job.status = i_last_byte;
        n_pos = (r_pos < PosMax) ? r_pos + 1'b1 : PosMax;
        // The old-format mark set by the last header byte already counts for its status.
        if (n_pos < POSITION_BITS'(HeaderBytes)) job.err = ErrShort;
        else if (n_err != ErrOk) job.err = n_err;
        else if ((n_pos - POSITION_BITS'(HeaderBytes)) < POSITION_BITS'(nraw))
            job.err = ErrFewByte;
        else if (n_left != 6'd0) job.err = ErrOverrun;
        else job.err = ErrOk;
        job.fcount = (job.err == ErrOk) ? capped[4:0] : 5'd0;
        if (!body) begin
            job.is_first = 1'b0;
            job.finish = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_last_byte)) begin
            r_pos <= '0; r_hdr <= '0; r_flags <= '0; r_left <= '0; r_slot <= '0;
            r_len <= '0; r_bleft <= '0; r_err <= '0;
        end else if (fire) begin
            r_pos <= n_pos; r_hdr <= n_hdr; r_flags <= n_flags; r_left <= n_left;
            r_slot <= n_slot; r_len <= n_len; r_bleft <= n_bleft; r_err <= n_err;
        end
    end

    assign o_job_valid = i_valid;
    assign o_job = job;
endmodule

// File: src/pivd_queue.sv
// Two-entry queue of byte jobs between the front and the back.
module pivd_queue import pivd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    `include "packed_inode_varint_decoder_top_macros.svh"
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    `PIVD_ASSERT(a_q_bound, i_clk, i_rst_n, r_cnt <= 2'd2, "queue count out of range")
    `PIVD_ASSERT_NEXT(a_q_full, i_clk, i_rst_n, r_cnt == 2'd2 && !pop, r_cnt == 2'd2,
        "full queue lost an entry")
    `PIVD_ASSERT_NEXT(a_q_empty, i_clk, i_rst_n, r_cnt == 2'd0 && !push, !o_valid,
        "empty queue produced an entry")
endmodule

// File: src/pivd_back.sv
// Back part: varint assembly and result emission through a small result queue.
module pivd_back import pivd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    input  logic [57:0] i_width_table,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);
    `include "packed_inode_varint_decoder_top_macros.svh"
    // Each job may yield two results; a four-entry output queue absorbs them.
    t_result r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_size;
    logic [63:0] vfull, v;
    logic [1:0] wc;
    logic [7:0] tab_sh;
    t_result res_a, res_b;
    logic have_a, have_b, take, pop;
    logic [1:0] npush;

    assign o_ready = r_cnt <= 3'd2;
    assign take = i_valid && o_ready;
    assign o_valid = r_cnt != 3'd0;
    assign pop = o_valid && i_ready;
    assign o_result = r_q[r_rp];

    always_comb begin
        n_acc = i_job.is_first ? 64'd0 : r_acc;
        if (i_job.len < 4'd9)
            n_acc = n_acc | ({56'd0, i_job.data} << {i_job.k[2:0], 3'd0});
        else if (i_job.k != 4'd0)
            n_acc = n_acc | ({56'd0, i_job.data} << {3'(i_job.k - 4'd1), 3'd0});
        vfull = (i_job.len < 4'd9) ? (n_acc >> i_job.len) : n_acc;
        tab_sh = {2'd0, i_job.slot, 1'b0};
        wc = (i_job.slot < 5'(TableSlots)) ? 2'(i_width_table >> tab_sh) : 2'd0;
        v = vfull & width_mask(wc);

        res_a = '0; res_b = '0; have_a = 1'b0; have_b = 1'b0;
        if (i_job.emit_hdr) begin
            have_a = 1'b1;
            res_a.kind = i_job.hdr_kind;
            res_a.value = i_job.hdr_value;
            res_a.width_code = (i_job.hdr_kind == KindSeed) ? 2'd3 :
                               (i_job.hdr_kind == KindFlags) ? 2'd2 : 2'd1;
        end else if (i_job.finish && !i_job.size_only) begin
            have_a = 1'b1;
            res_a.kind = KindVarint;
            res_a.slot = i_job.slot;
            res_a.value = v;
            res_a.width_code = wc;
        end
        if (i_job.status) begin
            have_b = 1'b1;
            res_b.kind = KindStatus;
            res_b.width_code = 2'd3;
            res_b.error_code = i_job.err;
            res_b.field_count = i_job.fcount;
            res_b.last_result = 1'b1;
            if (i_job.err == ErrOk && i_job.size_only)
                res_b.value = (i_job.finish && i_job.slot == 5'd8) ? v : r_size;
        end
        npush = {1'b0, have_a} + {1'b0, have_b};
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_acc <= n_acc;
            if (have_a) r_q[r_wp] <= res_a;
            if (have_b) r_q[have_a ? r_wp + 2'd1 : r_wp] <= res_b;
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_size <= '0;
        end else begin
            if (take) begin
                r_wp <= r_wp + npush;
                if (i_job.status) r_size <= '0;
                else if (i_job.finish && i_job.size_only && i_job.slot == 5'd8)
                    r_size <= v;
            end
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + (take ? {1'b0, npush} : 3'd0) - {2'd0, pop};
        end
    end

    `PIVD_ASSERT(a_b_bound, i_clk, i_rst_n, r_cnt <= 3'd4, "result queue overflow")
    `PIVD_ASSERT(a_b_last, i_clk, i_rst_n,
        !o_valid || (o_result.last_result == (o_result.kind == KindStatus)),
        "last mark not on the status result")
    `PIVD_ASSERT(a_b_err, i_clk, i_rst_n,
        !o_valid || o_result.kind == KindStatus || o_result.error_code == ErrOk,
        "error code outside the status result")
endmodule

// File: src/packed_inode_varint_decoder_top.sv
// Top level of the packed inode varint decoder.
//  channel | dir | handshake          | payload
//  input   | in  | i_valid / o_ready  | i_data_byte, i_last_byte
//  result  | out | o_valid / i_ready  | o_kind .. o_last_result
//  config  | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// One byte item is accepted per cycle while the job queue has room; the front state
// registers close the per-byte loop, so an unstalled stream sustains one item a cycle.
// A result passes through the registered job queue and result queue before it appears.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// Either side may stall independently; 2-entry job and 4-entry result queues absorb it.
module packed_inode_varint_decoder_top import pivd_pkg::*; #(
    parameter int unsigned MAX_FIELDS    = MaxFieldsDefault,
    parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [4:0]  o_slot,
    output logic [63:0] o_value,
    output logic [1:0]  o_width_code,
    output logic [2:0]  o_error_code,
    output logic [4:0]  o_field_count,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [57:0] i_cfg_data
);
    logic        r_size_only;
    logic [4:0]  r_new_fmt;
    logic [57:0] r_width_tab;
    logic        f_valid, f_ready, b_valid, b_ready;
    t_job        f_job, b_job;
    t_result     res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_only <= 1'b0; r_new_fmt <= 5'd31; r_width_tab <= WidthTableReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegSizeOnly: r_size_only <= i_cfg_data[0];
                RegNewFmt:   r_new_fmt <= i_cfg_data[4:0];
                RegWidthTab: r_width_tab <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pivd_front #(.MAX_FIELDS(MAX_FIELDS), .POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_last_byte,
        .i_size_only(r_size_only), .i_new_format_bit(r_new_fmt),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job));

    pivd_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(b_valid), .i_ready(b_ready), .o_job(b_job));

    pivd_back u_back (
        .i_clk, .i_rst_n, .i_valid(b_valid), .o_ready(b_ready), .i_job(b_job),
        .i_width_table(r_width_tab), .o_valid, .i_ready, .o_result(res));

    assign o_kind = res.kind;
    assign o_slot = res.slot;
    assign o_value = res.value;
    assign o_width_code = res.width_code;
    assign o_error_code = res.error_code;
    assign o_field_count = res.field_count;
    assign o_last_result = res.last_result;
endmodule
